### design/hrbp_pkg.sv
// shared types and constants for the http request byte parser
package hrbp_pkg;

   typedef struct packed {
      logic       cmd;
      logic [7:0] data_byte;
   } req_word_type;

   typedef struct packed {
      logic [7:0]  byte_echo;
      logic [3:0]  byte_kind;
      logic        token_end;
      logic [3:0]  ended_kind;
      logic [2:0]  method_code;
      logic [31:0] body_length;
      logic [1:0]  status;
   } rsp_word_type;

   // byte class flags computed by the front end
   typedef struct packed {
      logic restart;
      logic [7:0] data;
      logic is_cr;
      logic is_lf;
      logic is_blank;
      logic is_upper;
      logic is_digit;
      logic is_space;
   } cls_word_type;

   localparam logic [3:0] S_START = 4'd0;
   localparam logic [3:0] S_METHOD = 4'd1;
   localparam logic [3:0] S_BEFORE_URL = 4'd2;
   localparam logic [3:0] S_URL = 4'd3;
   localparam logic [3:0] S_QKEY = 4'd4;
   localparam logic [3:0] S_QVAL = 4'd5;
   localparam logic [3:0] S_BEFORE_PROTO = 4'd6;
   localparam logic [3:0] S_PROTO = 4'd7;
   localparam logic [3:0] S_BEFORE_VER = 4'd8;
   localparam logic [3:0] S_VER = 4'd9;
   localparam logic [3:0] S_HKEY = 4'd10;
   localparam logic [3:0] S_HVAL = 4'd11;
   localparam logic [3:0] S_BODY = 4'd12;
   localparam logic [3:0] S_DONE = 4'd13;
   localparam logic [3:0] S_BAD = 4'd14;

   localparam logic [3:0] K_NONE = 4'd0;
   localparam logic [3:0] K_METHOD = 4'd1;
   localparam logic [3:0] K_PATH = 4'd2;
   localparam logic [3:0] K_QKEY = 4'd3;
   localparam logic [3:0] K_QVAL = 4'd4;
   localparam logic [3:0] K_PROTO = 4'd5;
   localparam logic [3:0] K_VER = 4'd6;
   localparam logic [3:0] K_HNAME = 4'd7;
   localparam logic [3:0] K_HVAL = 4'd8;
   localparam logic [3:0] K_BODY = 4'd9;

   localparam logic [1:0] ST_BUSY = 2'd0;
   localparam logic [1:0] ST_DONE = 2'd1;
   localparam logic [1:0] ST_BAD = 2'd2;

   localparam int NAME_LEN = 14;

   function automatic logic [7:0] name_char(input logic [3:0] i);
      logic [7:0] c;
      case (i)
         4'd0: c = "C";
         4'd1: c = "o";
         4'd2: c = "n";
         4'd3: c = "t";
         4'd4: c = "e";
         4'd5: c = "n";
         4'd6: c = "t";
         4'd7: c = "-";
         4'd8: c = "L";
         4'd9: c = "e";
         4'd10: c = "n";
         4'd11: c = "g";
         4'd12: c = "t";
         4'd13: c = "h";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] meth_char(input logic [2:0] m, input logic [2:0] i);
      logic [47:0] t;
      logic [7:0] c;
      case (m)
         3'd0: t = {"GET", 24'h0};
         3'd1: t = {"POST", 16'h0};
         3'd2: t = {"HEAD", 16'h0};
         3'd3: t = {"PUT", 24'h0};
         3'd4: t = "DELETE";
         default: t = 48'h0;
      endcase
      case (i)
         3'd0: c = t[47:40];
         3'd1: c = t[39:32];
         3'd2: c = t[31:24];
         3'd3: c = t[23:16];
         3'd4: c = t[15:8];
         3'd5: c = t[7:0];
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [2:0] meth_len(input logic [2:0] m);
      logic [2:0] n;
      case (m)
         3'd0: n = 3'd3;
         3'd1: n = 3'd4;
         3'd2: n = 3'd4;
         3'd3: n = 3'd3;
         3'd4: n = 3'd6;
         default: n = 3'd0;
      endcase
      return n;
   endfunction

endpackage

### design/hrbp_front.sv
// input stage: accepts words and classifies the byte
module hrbp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  hrbp_pkg::req_word_type req_word,
   output logic                  cls_valid,
   input  logic                  cls_ready,
   output hrbp_pkg::cls_word_type cls_word
);
   logic                  valid_ff, valid_in;
   hrbp_pkg::cls_word_type word_ff, word_in;
   logic [7:0]            c;

   assign c = req_word.data_byte;
   assign full = valid_ff && !cls_ready;
   assign cls_valid = valid_ff;
   assign cls_word = word_ff;

   always_comb begin
      valid_in = valid_ff;
      word_in = word_ff;
      if (!full) begin
         valid_in = push;
         word_in.restart = req_word.cmd;
         word_in.data = c;
         word_in.is_cr = c == 8'h0d;
         word_in.is_lf = c == 8'h0a;
         word_in.is_blank = c == 8'h20 || c == 8'h09;
         word_in.is_upper = c >= 8'h41 && c <= 8'h5a;
         word_in.is_digit = c >= 8'h30 && c <= 8'h39;
         word_in.is_space = c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end
endmodule

### design/hrbp_back.sv
// parse state machine with output register
module hrbp_back #(
   parameter int LENGTH_BITS = 32,
   parameter int TOKEN_COUNT_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cls_valid,
   output logic                   cls_ready,
   input  hrbp_pkg::cls_word_type cls_word,
   output logic                   empty,
   input  logic                   pop,
   output hrbp_pkg::rsp_word_type rsp_word
);
   localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
   localparam logic [TOKEN_COUNT_BITS-1:0] TOK_MAX = {TOKEN_COUNT_BITS{1'b1}};

   logic [3:0]                  state_ff, state_in;
   logic [TOKEN_COUNT_BITS-1:0] tok_ff, tok_in;
   logic [4:0]                  mm_ff, mm_in;
   logic [3:0]                  nidx_ff, nidx_in;
   logic                        nok_ff, nok_in;
   logic                        vlen_ff, vlen_in;
   logic                        dopen_ff, dopen_in;
   logic                        started_ff, started_in;
   logic                        neg_ff, neg_in;
   logic [LENGTH_BITS-1:0]      len_ff, len_in;
   logic [LENGTH_BITS-1:0]      body_ff, body_in;
   logic                        plf_ff, plf_in;
   logic                        ovalid_ff, ovalid_in;
   hrbp_pkg::rsp_word_type      out_ff, out_in;

   logic        take;
   logic [7:0]  c;
   logic [3:0]  kind, ended;
   logic        tend, grow;
   logic [2:0]  mcode;
   logic [LENGTH_BITS+3:0] len_x10;
   logic [LENGTH_BITS-1:0] body_inc;
   logic [31:0] len_out;

   assign cls_ready = !ovalid_ff || pop;
   assign take = cls_valid && cls_ready;
   assign empty = !ovalid_ff;
   assign rsp_word = out_ff;
   assign c = cls_word.data;
   assign len_x10 = {4'b0, len_ff} * (LENGTH_BITS + 4)'(10) + (LENGTH_BITS + 4)'(c - 8'h30);
   assign body_inc = (body_ff == LEN_MAX) ? body_ff : body_ff + 1'b1;

   always_comb begin
      state_in = state_ff; tok_in = tok_ff; mm_in = mm_ff; nidx_in = nidx_ff;
      nok_in = nok_ff; vlen_in = vlen_ff; dopen_in = dopen_ff;
      started_in = started_ff; neg_in = neg_ff; len_in = len_ff;
      body_in = body_ff; plf_in = plf_ff;
      kind = hrbp_pkg::K_NONE; ended = hrbp_pkg::K_NONE; tend = 1'b0;
      mcode = 3'd0; grow = 1'b0;
      if (cls_word.restart) begin
         state_in = hrbp_pkg::S_START; tok_in = '0; mm_in = 5'h1f; nidx_in = '0;
         nok_in = 1'b1; vlen_in = 1'b0; dopen_in = 1'b1; started_in = 1'b0;
         neg_in = 1'b0; len_in = '0; body_in = '0; plf_in = 1'b0;
      end else begin
         case (state_ff)
            hrbp_pkg::S_START, hrbp_pkg::S_METHOD: begin
               if (cls_word.is_upper) begin
                  for (int m = 0; m < 5; m++) begin
                     if (tok_ff >= TOKEN_COUNT_BITS'(hrbp_pkg::meth_len(3'(m)))
                         || hrbp_pkg::meth_char(3'(m), tok_ff[2:0]) != c)
                        mm_in[m] = 1'b0;
                  end
                  grow = 1'b1; kind = hrbp_pkg::K_METHOD;
                  state_in = hrbp_pkg::S_METHOD;
               end else if (state_ff == hrbp_pkg::S_START) begin
                  if (!(cls_word.is_cr || cls_word.is_lf || cls_word.is_blank))
                     state_in = hrbp_pkg::S_BAD;
               end else if (cls_word.is_blank) begin
                  for (int m = 4; m >= 0; m--) begin
                     if (mm_ff[m] && tok_ff == TOKEN_COUNT_BITS'(hrbp_pkg::meth_len(3'(m))))
                        mcode = 3'(m + 1);
                  end
                  tend = 1'b1; ended = hrbp_pkg::K_METHOD; tok_in = '0;
                  state_in = (mcode != 3'd0) ? hrbp_pkg::S_BEFORE_URL : hrbp_pkg::S_BAD;
               end else state_in = hrbp_pkg::S_BAD;
            end
            hrbp_pkg::S_BEFORE_URL: begin
               if (c == "/") begin
                  grow = 1'b1; kind = hrbp_pkg::K_PATH; state_in = hrbp_pkg::S_URL;
               end else if (!cls_word.is_blank) state_in = hrbp_pkg::S_BAD;
            end
            hrbp_pkg::S_URL: begin
               if (c == "?" || cls_word.is_blank) begin
                  tend = 1'b1; ended = hrbp_pkg::K_PATH; tok_in = '0;
                  state_in = (c == "?") ? hrbp_pkg::S_QKEY : hrbp_pkg::S_BEFORE_PROTO;
               end else begin
                  grow = 1'b1; kind = hrbp_pkg::K_PATH;
               end
            end
            hrbp_pkg::S_QKEY: begin
               if (c == "=") begin
                  tend = 1'b1; ended = hrbp_pkg::K_QKEY; tok_in = '0;
                  state_in = hrbp_pkg::S_QVAL;
               end else if (cls_word.is_blank || cls_word.is_cr || cls_word.is_lf)
                  state_in = hrbp_pkg::S_BAD;
               else begin
                  grow = 1'b1; kind = hrbp_pkg::K_QKEY;
               end
            end
            hrbp_pkg::S_QVAL: begin
               if (c == "&" || cls_word.is_blank) begin
                  tend = 1'b1; ended = hrbp_pkg::K_QVAL; tok_in = '0;
                  state_in = (c == "&") ? hrbp_pkg::S_QKEY : hrbp_pkg::S_BEFORE_PROTO;
               end else begin
                  grow = 1'b1; kind = hrbp_pkg::K_QVAL;
               end
            end
            hrbp_pkg::S_BEFORE_PROTO: begin
               if (cls_word.is_upper) begin
                  grow = 1'b1; kind = hrbp_pkg::K_PROTO; state_in = hrbp_pkg::S_PROTO;
               end else if (!cls_word.is_blank) state_in = hrbp_pkg::S_BAD;
            end
            hrbp_pkg::S_PROTO: begin
               if (c == "/") begin
                  tend = 1'b1; ended = hrbp_pkg::K_PROTO; tok_in = '0;
                  state_in = hrbp_pkg::S_BEFORE_VER;
               end else if (cls_word.is_upper) begin
                  grow = 1'b1; kind = hrbp_pkg::K_PROTO;
               end else state_in = hrbp_pkg::S_BAD;
            end
            hrbp_pkg::S_BEFORE_VER: begin
               if (cls_word.is_digit) begin
                  grow = 1'b1; kind = hrbp_pkg::K_VER; state_in = hrbp_pkg::S_VER;
               end else state_in = hrbp_pkg::S_BAD;
            end
            hrbp_pkg::S_VER: begin
               if (cls_word.is_cr) begin
                  tend = 1'b1; ended = hrbp_pkg::K_VER; tok_in = '0;
                  state_in = hrbp_pkg::S_HKEY;
               end else if (cls_word.is_digit || c == ".") begin
                  grow = 1'b1; kind = hrbp_pkg::K_VER;
               end else state_in = hrbp_pkg::S_BAD;
            end
            hrbp_pkg::S_HKEY: begin
               if (cls_word.is_lf) begin
               end else if (cls_word.is_cr) begin
                  if (tok_ff == '0) begin
                     if (len_ff != '0 && !neg_ff) begin
                        state_in = hrbp_pkg::S_BODY; plf_in = 1'b1;
                     end else state_in = hrbp_pkg::S_DONE;
                  end else state_in = hrbp_pkg::S_BAD;
               end else if (c == ":") begin
                  tend = 1'b1; ended = hrbp_pkg::K_HNAME; tok_in = '0;
                  vlen_in = nok_ff && nidx_ff == 4'(hrbp_pkg::NAME_LEN);
                  if (vlen_in) begin
                     len_in = '0; neg_in = 1'b0; started_in = 1'b0; dopen_in = 1'b1;
                  end
                  nidx_in = '0; nok_in = 1'b1; state_in = hrbp_pkg::S_HVAL;
               end else begin
                  if (nidx_ff < 4'(hrbp_pkg::NAME_LEN) && hrbp_pkg::name_char(nidx_ff) == c)
                     nidx_in = nidx_ff + 4'd1;
                  else nok_in = 1'b0;
                  grow = 1'b1; kind = hrbp_pkg::K_HNAME;
               end
            end
            hrbp_pkg::S_HVAL: begin
               if (tok_ff == '0 && cls_word.is_blank) begin
               end else if (cls_word.is_cr) begin
                  tend = 1'b1; ended = hrbp_pkg::K_HVAL; tok_in = '0;
                  vlen_in = 1'b0; state_in = hrbp_pkg::S_HKEY;
               end else begin
                  if (vlen_ff && dopen_ff) begin
                     if (!started_ff && cls_word.is_space) begin
                     end else if (!started_ff && (c == "+" || c == "-")) begin
                        started_in = 1'b1; neg_in = c == "-";
                     end else if (cls_word.is_digit) begin
                        started_in = 1'b1;
                        len_in = (len_x10[LENGTH_BITS+3:LENGTH_BITS] != 4'd0)
                                 ? LEN_MAX : len_x10[LENGTH_BITS-1:0];
                     end else dopen_in = 1'b0;
                  end
                  grow = 1'b1; kind = hrbp_pkg::K_HVAL;
               end
            end
            hrbp_pkg::S_BODY: begin
               plf_in = 1'b0;
               if (!(plf_ff && cls_word.is_lf)) begin
                  kind = hrbp_pkg::K_BODY; body_in = body_inc;
                  if (body_inc >= len_ff) begin
                     tend = 1'b1; ended = hrbp_pkg::K_BODY; state_in = hrbp_pkg::S_DONE;
                  end
               end
            end
            default: begin
            end
         endcase
         if (grow && tok_ff != TOK_MAX) tok_in = tok_ff + 1'b1;
      end
   end

   always_comb begin
      len_out = 32'(len_in);
      out_in = out_ff;
      ovalid_in = ovalid_ff && !pop;
      if (take) begin
         ovalid_in = 1'b1;
         out_in.byte_echo = c;
         out_in.byte_kind = kind;
         out_in.token_end = tend;
         out_in.ended_kind = ended;
         out_in.method_code = mcode;
         out_in.body_length = neg_in ? 32'd0 : len_out;
         out_in.status = (state_in == hrbp_pkg::S_DONE) ? hrbp_pkg::ST_DONE :
                         (state_in == hrbp_pkg::S_BAD) ? hrbp_pkg::ST_BAD : hrbp_pkg::ST_BUSY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hrbp_pkg::S_START; tok_ff <= '0; mm_ff <= 5'h1f; nidx_ff <= '0;
         nok_ff <= 1'b1; vlen_ff <= 1'b0; dopen_ff <= 1'b1; started_ff <= 1'b0;
         neg_ff <= 1'b0; len_ff <= '0; body_ff <= '0; plf_ff <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         if (take) begin
            state_ff <= state_in; tok_ff <= tok_in; mm_ff <= mm_in; nidx_ff <= nidx_in;
            nok_ff <= nok_in; vlen_ff <= vlen_in; dopen_ff <= dopen_in;
            started_ff <= started_in; neg_ff <= neg_in; len_ff <= len_in;
            body_ff <= body_in; plf_ff <= plf_in;
         end
         ovalid_ff <= ovalid_in;
      end
      out_ff <= out_in;
   end
endmodule

### design/http_request_byte_parser_top.sv
// top level of the http request byte parser
// path: a request word is registered in the front stage, then parsed and registered in the output stage
// throughput: one word per cycle while pop keeps draining the output register; a stall on pop holds the front stage
// reset: synchronous active-high reset clears the parser to its start state
// and empties both internal stages
module http_request_byte_parser_top #(
   parameter int LENGTH_BITS = 32,
   parameter int TOKEN_COUNT_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  hrbp_pkg::req_word_type req_word,
   output logic                   empty,
   input  logic                   pop,
   output hrbp_pkg::rsp_word_type rsp_word
);
   logic                   cls_valid, cls_ready;
   hrbp_pkg::cls_word_type cls_word;

   hrbp_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_word(req_word),
      .cls_valid(cls_valid), .cls_ready(cls_ready), .cls_word(cls_word)
   );

   hrbp_back #(.LENGTH_BITS(LENGTH_BITS), .TOKEN_COUNT_BITS(TOKEN_COUNT_BITS)) u_back (
      .clock(clock), .reset(reset), .cls_valid(cls_valid), .cls_ready(cls_ready),
      .cls_word(cls_word), .empty(empty), .pop(pop), .rsp_word(rsp_word)
   );
endmodule

### design/hrbp_checker.sv
// port-level checks for the parser top level
module hrbp_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   full,
   input logic                   empty,
   input logic                   pop,
   input hrbp_pkg::rsp_word_type rsp_word
);
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_word)) else $error("response changed");
   a_end_kind: assert property (@(posedge clock) disable iff (reset)
      !empty && !rsp_word.token_end |-> rsp_word.ended_kind == hrbp_pkg::K_NONE)
      else $error("ended kind without token end");
   a_method: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_word.method_code != 3'd0 |->
         rsp_word.token_end && rsp_word.ended_kind == hrbp_pkg::K_METHOD)
      else $error("method code off method end");
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> empty && !full) else $error("not empty after reset");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      empty |-> !full) else $error("full with empty output");
endmodule

bind http_request_byte_parser_top hrbp_checker u_hrbp_checker (
   .clock(clock), .reset(reset), .full(full), .empty(empty),
   .pop(pop), .rsp_word(rsp_word)
);

### verif/http_request_byte_parser_checker.sv
// checker for the http request byte parser: predicts each response word and compares
`timescale 1ns / 100ps
module http_request_byte_parser_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic                   full,
   input  hrbp_pkg::req_word_type req_word,
   input  logic                   empty,
   input  logic                   pop,
   input  hrbp_pkg::rsp_word_type rsp_word,
   output int                     fail_count,
   output int                     pending_count
);

   localparam logic [31:0] LEN_SAT = 32'hffff_ffff;
   localparam logic [15:0] TOK_SAT = 16'hffff;

   logic [3:0]  pstate;
   logic [15:0] tok_len;
   logic [4:0]  meth_ok;
   logic [3:0]  name_idx;
   logic        name_ok;
   logic        val_is_len;
   logic        digits_open;
   logic        len_started;
   logic        len_neg;
   logic [31:0] len_val;
   logic [31:0] body_cnt;
   logic        lf_due;

   hrbp_pkg::rsp_word_type expected_words[$];

   assign pending_count = expected_words.size();

   function automatic logic is_blank(input logic [7:0] c);
      return c == 8'h20 || c == 8'h09;
   endfunction

   function automatic logic is_upper(input logic [7:0] c);
      return c >= "A" && c <= "Z";
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic [7:0] method_letter(input int m, input int i);
      string s;
      case (m)
         0: s = "GET";
         1: s = "POST";
         2: s = "HEAD";
         3: s = "PUT";
         default: s = "DELETE";
      endcase
      return (i < s.len()) ? s[i] : 8'h00;
   endfunction

   function automatic int method_size(input int m);
      case (m)
         0: return 3;
         1: return 4;
         2: return 4;
         3: return 3;
         default: return 6;
      endcase
   endfunction

   task automatic clear_parser();
      pstate = hrbp_pkg::S_START;
      tok_len = '0;
      meth_ok = 5'h1f;
      name_idx = '0;
      name_ok = 1'b1;
      val_is_len = 1'b0;
      digits_open = 1'b1;
      len_started = 1'b0;
      len_neg = 1'b0;
      len_val = '0;
      body_cnt = '0;
      lf_due = 1'b0;
   endtask

   task automatic grow_token();
      if (tok_len != TOK_SAT) tok_len++;
   endtask

   task automatic take_length_char(input logic [7:0] c);
      logic [63:0] v;
      if (!digits_open) return;
      if (!len_started) begin
         if (c == 8'h20 || (c >= 8'd9 && c <= 8'd13)) return;
         if (c == "+" || c == "-") begin
            len_started = 1'b1;
            len_neg = (c == "-");
            return;
         end
      end
      if (is_digit(c)) begin
         len_started = 1'b1;
         v = {32'h0, len_val} * 64'd10 + 64'(c - 8'h30);
         len_val = (v > 64'(LEN_SAT)) ? LEN_SAT : v[31:0];
      end else begin
         digits_open = 1'b0;
      end
   endtask

   task automatic parse_byte(input hrbp_pkg::req_word_type w,
                             output hrbp_pkg::rsp_word_type r);
      logic [7:0] c;
      int m;
      c = w.data_byte;
      r = '0;
      r.byte_echo = c;
      if (w.cmd) begin
         clear_parser();
      end else begin
         case (pstate)
            hrbp_pkg::S_START: begin
               if (c == 8'h0d || c == 8'h0a || is_blank(c)) begin
               end else if (is_upper(c)) begin
                  for (m = 0; m < 5; m++)
                     if (tok_len >= method_size(m) || method_letter(m, tok_len) != c)
                        meth_ok[m] = 1'b0;
                  grow_token();
                  r.byte_kind = hrbp_pkg::K_METHOD;
                  pstate = hrbp_pkg::S_METHOD;
               end else pstate = hrbp_pkg::S_BAD;
            end
            hrbp_pkg::S_METHOD: begin
               if (is_upper(c)) begin
                  for (m = 0; m < 5; m++)
                     if (tok_len >= method_size(m) || method_letter(m, tok_len) != c)
                        meth_ok[m] = 1'b0;
                  grow_token();
                  r.byte_kind = hrbp_pkg::K_METHOD;
               end else if (is_blank(c)) begin
                  for (m = 4; m >= 0; m--)
                     if (meth_ok[m] && tok_len == method_size(m)) r.method_code = 3'(m + 1);
                  r.token_end = 1'b1;
                  r.ended_kind = hrbp_pkg::K_METHOD;
                  tok_len = '0;
                  pstate = (r.method_code != 3'd0) ? hrbp_pkg::S_BEFORE_URL : hrbp_pkg::S_BAD;
               end else pstate = hrbp_pkg::S_BAD;
            end
            hrbp_pkg::S_BEFORE_URL: begin
               if (c == "/") begin
                  grow_token();
                  r.byte_kind = hrbp_pkg::K_PATH;
                  pstate = hrbp_pkg::S_URL;
               end else if (!is_blank(c)) pstate = hrbp_pkg::S_BAD;
            end
            hrbp_pkg::S_URL: begin
               if (c == "?" || is_blank(c)) begin
                  r.token_end = 1'b1;
                  r.ended_kind = hrbp_pkg::K_PATH;
                  tok_len = '0;
                  pstate = (c == "?") ? hrbp_pkg::S_QKEY : hrbp_pkg::S_BEFORE_PROTO;
               end else begin
                  grow_token();
                  r.byte_kind = hrbp_pkg::K_PATH;
               end
            end
            hrbp_pkg::S_QKEY: begin
               if (c == "=") begin
                  r.token_end = 1'b1;
                  r.ended_kind = hrbp_pkg::K_QKEY;
                  tok_len = '0;
                  pstate = hrbp_pkg::S_QVAL;
               end else if (is_blank(c) || c == 8'h0d || c == 8'h0a) pstate = hrbp_pkg::S_BAD;
               else begin
                  grow_token();
                  r.byte_kind = hrbp_pkg::K_QKEY;
               end
            end
            hrbp_pkg::S_QVAL: begin
               if (c == "&" || is_blank(c)) begin
                  r.token_end = 1'b1;
                  r.ended_kind = hrbp_pkg::K_QVAL;
                  tok_len = '0;
                  pstate = (c == "&") ? hrbp_pkg::S_QKEY : hrbp_pkg::S_BEFORE_PROTO;
               end else begin
                  grow_token();
                  r.byte_kind = hrbp_pkg::K_QVAL;
               end
            end
            hrbp_pkg::S_BEFORE_PROTO: begin
               if (is_blank(c)) begin
               end else if (is_upper(c)) begin
                  grow_token();
                  r.byte_kind = hrbp_pkg::K_PROTO;
                  pstate = hrbp_pkg::S_PROTO;
               end else pstate = hrbp_pkg::S_BAD;
            end
            hrbp_pkg::S_PROTO: begin
               if (c == "/") begin
                  r.token_end = 1'b1;
                  r.ended_kind = hrbp_pkg::K_PROTO;
                  tok_len = '0;
                  pstate = hrbp_pkg::S_BEFORE_VER;
               end else if (is_upper(c)) begin
                  grow_token();
                  r.byte_kind = hrbp_pkg::K_PROTO;
               end else pstate = hrbp_pkg::S_BAD;
            end
            hrbp_pkg::S_BEFORE_VER: begin
               if (is_digit(c)) begin
                  grow_token();
                  r.byte_kind = hrbp_pkg::K_VER;
                  pstate = hrbp_pkg::S_VER;
               end else pstate = hrbp_pkg::S_BAD;
            end
            hrbp_pkg::S_VER: begin
               if (c == 8'h0d) begin
                  r.token_end = 1'b1;
                  r.ended_kind = hrbp_pkg::K_VER;
                  tok_len = '0;
                  pstate = hrbp_pkg::S_HKEY;
               end else if (is_digit(c) || c == ".") begin
                  grow_token();
                  r.byte_kind = hrbp_pkg::K_VER;
               end else pstate = hrbp_pkg::S_BAD;
            end
            hrbp_pkg::S_HKEY: begin
               if (c == 8'h0a) begin
               end else if (c == 8'h0d) begin
                  if (tok_len == 0) begin
                     if (len_val != 0 && !len_neg) begin
                        pstate = hrbp_pkg::S_BODY;
                        lf_due = 1'b1;
                     end else pstate = hrbp_pkg::S_DONE;
                  end else pstate = hrbp_pkg::S_BAD;
               end else if (c == ":") begin
                  r.token_end = 1'b1;
                  r.ended_kind = hrbp_pkg::K_HNAME;
                  tok_len = '0;
                  val_is_len = name_ok && name_idx == 4'(hrbp_pkg::NAME_LEN);
                  if (val_is_len) begin
                     len_val = '0;
                     len_neg = 1'b0;
                     len_started = 1'b0;
                     digits_open = 1'b1;
                  end
                  name_idx = '0;
                  name_ok = 1'b1;
                  pstate = hrbp_pkg::S_HVAL;
               end else begin
                  if (name_idx < 4'(hrbp_pkg::NAME_LEN) && hrbp_pkg::name_char(name_idx) == c)
                     name_idx++;
                  else name_ok = 1'b0;
                  grow_token();
                  r.byte_kind = hrbp_pkg::K_HNAME;
               end
            end
            hrbp_pkg::S_HVAL: begin
               if (tok_len == 0 && is_blank(c)) begin
               end else if (c == 8'h0d) begin
                  r.token_end = 1'b1;
                  r.ended_kind = hrbp_pkg::K_HVAL;
                  tok_len = '0;
                  val_is_len = 1'b0;
                  pstate = hrbp_pkg::S_HKEY;
               end else begin
                  if (val_is_len) take_length_char(c);
                  grow_token();
                  r.byte_kind = hrbp_pkg::K_HVAL;
               end
            end
            hrbp_pkg::S_BODY: begin
               if (lf_due && c == 8'h0a) begin
                  lf_due = 1'b0;
               end else begin
                  lf_due = 1'b0;
                  r.byte_kind = hrbp_pkg::K_BODY;
                  if (body_cnt != LEN_SAT) body_cnt++;
                  if (body_cnt >= len_val) begin
                     r.token_end = 1'b1;
                     r.ended_kind = hrbp_pkg::K_BODY;
                     pstate = hrbp_pkg::S_DONE;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      r.body_length = len_neg ? 32'h0 : len_val;
      r.status = (pstate == hrbp_pkg::S_DONE) ? hrbp_pkg::ST_DONE :
                 (pstate == hrbp_pkg::S_BAD) ? hrbp_pkg::ST_BAD : hrbp_pkg::ST_BUSY;
   endtask

   always @(posedge clock) begin
      hrbp_pkg::rsp_word_type r;
      hrbp_pkg::rsp_word_type e;
      if (reset) begin
         clear_parser();
         expected_words.delete();
         fail_count <= 0;
      end else begin
         if (push && !full) begin
            parse_byte(req_word, r);
            expected_words.push_back(r);
         end
         if (pop && !empty) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected response word %h", $time, rsp_word);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_words.pop_front();
               if (e !== rsp_word) begin
                  $display("%0t: mismatch expected %h actual %h", $time, e, rsp_word);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

### verif/tb.sv
// testbench top for the http request byte parser: stimulus and verdict
`timescale 1ns / 100ps
module tb;

   logic                   clock;
   logic                   reset;
   logic                   push;
   logic                   full;
   hrbp_pkg::req_word_type req_word;
   logic                   empty;
   logic                   pop;
   hrbp_pkg::rsp_word_type rsp_word;
   int                     fail_count;
   int                     pending_count;
   int                     send_idle_pct;
   int                     recv_idle_pct;
   int                     hold_cycles;
   int                     hold_seen;
   int                     hold_req = 0;
   int                     cycle_count = 0;
   int                     bytes_sent;

   http_request_byte_parser_top dut (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_word(req_word),
      .empty(empty), .pop(pop), .rsp_word(rsp_word)
   );

   http_request_byte_parser_checker checker_inst (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_word(req_word),
      .empty(empty), .pop(pop), .rsp_word(rsp_word),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("http_request_byte_parser_top test failed");
         $finish;
      end
   end

   // receiver: random stall plus long hold-off
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
         hold_cycles <= 0;
         hold_seen <= 0;
      end else if (hold_seen != hold_req) begin
         hold_seen <= hold_req;
         hold_cycles <= 60;
         pop <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         pop <= 1'b0;
      end else pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_word(input logic cmd, input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push <= 1'b1;
      req_word <= '{cmd: cmd, data_byte: b};
      @(posedge clock);
      while (full) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_word(1'b0, s[i]);
   endtask

   task automatic random_request();
      string meth[6] = '{"GET", "POST", "HEAD", "PUT", "DELETE", "PATCH"};
      string s;
      int n;
      int blen;
      send_word(1'b1, 8'($urandom_range(255)));
      s = {meth[$urandom_range(5)], " /p"};
      if ($urandom_range(1)) s = {s, "?k=v&a=b"};
      s = {s, " HTTP/1.1\015\n"};
      if ($urandom_range(3) != 0) begin
         blen = $urandom_range(6);
         s = {s, $sformatf("Content-Length: %0d\015\n", blen)};
      end
      if ($urandom_range(3) == 0) s = {s, "Content-Lengtx:5\015\nX: y\015\n"};
      if ($urandom_range(7) == 0) s = {s, "Content-Length: -3\015\n"};
      s = {s, "\015\n"};
      send_text(s);
      n = $urandom_range(8);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) == 0) send_word(1'b0, 8'($urandom_range(255)));
         else send_word(1'b0, 8'("a" + $urandom_range(25)));
      end
   endtask

   task automatic run_phase(input int sidle, input int ridle, input int nbytes);
      int target;
      send_idle_pct = sidle;
      recv_idle_pct = ridle;
      target = bytes_sent + nbytes;
      while (bytes_sent < target) begin
         if ($urandom_range(4) == 0) begin
            send_word($urandom_range(7) == 0, 8'($urandom_range(255)));
         end else random_request();
      end
   endtask

   initial begin
      reset = 1'b1;
      push = 1'b0;
      req_word = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      bytes_sent = 0;
      repeat (4) @(negedge clock);
      reset = 1'b0;
      send_text("DELETE /a?x=1 HTTP/1.1\015\nContent-Length: 99999999999\015\n");
      send_word(1'b1, 8'hff);
      send_text("POST / HTTP/1.1\015\nContent-Length: +2\015\n\015\n\nxy\xff");
      send_word(1'b1, 8'h00);
      send_text("GET\x80");
      hold_req = hold_req + 1;
      send_word(1'b1, 8'h00);
      send_text("XYZ / HTTP/1.1\015\n");
      push <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      run_phase(22, 64, 650);
      run_phase(64, 22, 650);
      run_phase(0, 0, 650);
      push <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0) $display("http_request_byte_parser_top test passed");
      else $display("http_request_byte_parser_top test failed");
      $finish;
   end

endmodule

### files.f
design/hrbp_pkg.sv
design/hrbp_front.sv
design/hrbp_back.sv
design/http_request_byte_parser_top.sv
design/hrbp_checker.sv
verif/http_request_byte_parser_checker.sv
verif/tb.sv
